FILE: design/cfa_pkg.sv
// Package with the shared codes, state type and month-length function of the calendar adjuster.
package cfa_pkg;

    // Action codes carried in the input transfer.
    localparam logic [2:0] ACT_INC     = 3'd0;
    localparam logic [2:0] ACT_DEC     = 3'd1;
    localparam logic [2:0] ACT_SEL_12H = 3'd2;
    localparam logic [2:0] ACT_SEL_24H = 3'd3;
    localparam logic [2:0] ACT_LOAD    = 3'd4;

    // Field codes carried in the input transfer.
    localparam logic [2:0] FLD_HOUR   = 3'd0;
    localparam logic [2:0] FLD_MINUTE = 3'd1;
    localparam logic [2:0] FLD_PM     = 3'd2;
    localparam logic [2:0] FLD_MONTH  = 3'd3;
    localparam logic [2:0] FLD_DAY    = 3'd4;
    localparam logic [2:0] FLD_YEAR   = 3'd5;

    // Packed widths of the two stream payloads.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // One input item as held in the input register.
    typedef struct packed {
        logic [2:0] action;
        logic [2:0] field;
        logic [6:0] value;
    } t_cmd;

    // Complete calendar state, which is also the result item.
    typedef struct packed {
        logic       twelve_hour;
        logic [6:0] year;
        logic [4:0] day;
        logic [3:0] month;
        logic       pm;
        logic [5:0] minute;
        logic [4:0] hour;
    } t_cal_state;

    // Length of a month; the year is counted from 2000.
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
        logic leap;
        begin
            leap = (y[1:0] == 2'd0) && (y != 7'd100);
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: month_length = 5'd30;
                4'd2:                    month_length = leap ? 5'd29 : 5'd28;
                default:                 month_length = 5'd31;
            endcase
        end
    endfunction

endpackage

FILE: design/cfa_next_state.sv
// Combinational update of the calendar state for one command.
module cfa_next_state (
    input  cfa_pkg::t_cmd       i_cmd,
    input  cfa_pkg::t_cal_state i_cur,
    output cfa_pkg::t_cal_state o_nxt
);
    import cfa_pkg::*;

    logic [5:0] w_hour;
    logic [5:0] w_day;
    logic [4:0] w_len;
    logic [4:0] w_new_len;
    logic       w_fix_day;
    logic       w_up;

    // Apply the requested step, mode change or load, then clamp the day.
    always_comb begin
        o_nxt     = i_cur;
        w_up      = (i_cmd.action == ACT_INC);
        w_fix_day = 1'b0;
        w_len     = month_length(i_cur.month, i_cur.year);
        w_hour    = {1'b0, i_cur.hour};
        w_day     = {1'b0, i_cur.day};
        case (i_cmd.action)
            ACT_INC, ACT_DEC: begin
                case (i_cmd.field)
                    FLD_HOUR: begin
                        if (i_cur.twelve_hour) begin
                            if (w_up) begin
                                w_hour = (w_hour + 6'd1 > 6'd12) ? w_hour - 6'd11 : w_hour + 6'd1;
                            end else begin
                                w_hour = (w_hour < 6'd2) ? w_hour + 6'd11 : w_hour - 6'd1;
                            end
                        end else begin
                            if (w_up) begin
                                w_hour = (w_hour + 6'd1 > 6'd23) ? w_hour - 6'd23 : w_hour + 6'd1;
                            end else begin
                                w_hour = (w_hour == 6'd0) ? 6'd23 : w_hour - 6'd1;
                            end
                        end
                        o_nxt.hour = w_hour[4:0];
                    end
                    FLD_MINUTE: begin
                        if (w_up) begin
                            o_nxt.minute = (i_cur.minute >= 6'd59) ? i_cur.minute - 6'd59
                                                                   : i_cur.minute + 6'd1;
                        end else begin
                            o_nxt.minute = (i_cur.minute == 6'd0) ? 6'd59 : i_cur.minute - 6'd1;
                        end
                    end
                    FLD_PM: begin
                        o_nxt.pm = ~i_cur.pm;
                    end
                    FLD_MONTH: begin
                        if (w_up) begin
                            o_nxt.month = (i_cur.month >= 4'd12) ? i_cur.month - 4'd11
                                                                 : i_cur.month + 4'd1;
                        end else begin
                            o_nxt.month = (i_cur.month < 4'd2) ? i_cur.month + 4'd11
                                                               : i_cur.month - 4'd1;
                        end
                        w_fix_day = 1'b1;
                    end
                    FLD_DAY: begin
                        if (w_up) begin
                            w_day = (w_day + 6'd1 > {1'b0, w_len})
                                    ? w_day + 6'd1 - {1'b0, w_len} : w_day + 6'd1;
                        end else begin
                            w_day = (w_day < 6'd2) ? w_day - 6'd1 + {1'b0, w_len}
                                                   : w_day - 6'd1;
                        end
                        o_nxt.day = w_day[4:0];
                    end
                    FLD_YEAR: begin
                        if (w_up) begin
                            o_nxt.year = (i_cur.year >= 7'd99) ? i_cur.year - 7'd99
                                                               : i_cur.year + 7'd1;
                        end else begin
                            o_nxt.year = (i_cur.year == 7'd0) ? 7'd99 : i_cur.year - 7'd1;
                        end
                        w_fix_day = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_SEL_12H: begin
                o_nxt.twelve_hour = 1'b1;
                if (i_cur.hour > 5'd12) begin
                    o_nxt.hour = i_cur.hour - 5'd12;
                    o_nxt.pm   = 1'b1;
                end
            end
            ACT_SEL_24H: begin
                o_nxt.twelve_hour = 1'b0;
                if (i_cur.pm && (i_cur.hour < 5'd12)) begin
                    o_nxt.hour = i_cur.hour + 5'd12;
                end
            end
            ACT_LOAD: begin
                case (i_cmd.field)
                    FLD_HOUR: begin
                        if (i_cur.twelve_hour) begin
                            if (i_cmd.value < 7'd1) begin
                                o_nxt.hour = 5'd1;
                            end else if (i_cmd.value > 7'd12) begin
                                o_nxt.hour = 5'd12;
                            end else begin
                                o_nxt.hour = i_cmd.value[4:0];
                            end
                        end else begin
                            o_nxt.hour = (i_cmd.value > 7'd23) ? 5'd23 : i_cmd.value[4:0];
                        end
                    end
                    FLD_MINUTE: begin
                        o_nxt.minute = (i_cmd.value > 7'd59) ? 6'd59 : i_cmd.value[5:0];
                    end
                    FLD_PM: begin
                        o_nxt.pm = (i_cmd.value != 7'd0);
                    end
                    FLD_MONTH: begin
                        if (i_cmd.value < 7'd1) begin
                            o_nxt.month = 4'd1;
                        end else if (i_cmd.value > 7'd12) begin
                            o_nxt.month = 4'd12;
                        end else begin
                            o_nxt.month = i_cmd.value[3:0];
                        end
                        w_fix_day = 1'b1;
                    end
                    FLD_DAY: begin
                        if (i_cmd.value < 7'd1) begin
                            o_nxt.day = 5'd1;
                        end else if (i_cmd.value > {2'b00, w_len}) begin
                            o_nxt.day = w_len;
                        end else begin
                            o_nxt.day = i_cmd.value[4:0];
                        end
                    end
                    FLD_YEAR: begin
                        o_nxt.year = (i_cmd.value > 7'd99) ? 7'd99 : i_cmd.value;
                        w_fix_day = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // A new month or year can shorten the month below the current day.
        w_new_len = month_length(o_nxt.month, o_nxt.year);
        if (w_fix_day && (o_nxt.day > w_new_len)) begin
            o_nxt.day = w_new_len;
        end
    end

endmodule

FILE: design/calendar_field_adjuster_core.sv
// Top level of the calendar adjuster: input register, state update and result register.
//
//  Channel   | Direction | Payload (lowest bit first)
//  s_axis    | in        | action[2:0], field[5:3], value[12:6], zero to bit 15
//  m_axis    | out       | hour, minute, pm, month, day, year, twelve_hour, zero to bit 31
//
// Each command is held in the input register and is then applied to the state; the
// updated state, held in the state register, is the result.
// One command is taken per cycle while the result is not stalled; the single state
// update between the two registers sets that figure. Reset returns the state to
// 08:00 AM, 1 January 2000, 12-hour mode. A stalled result holds the state, and the
// input register takes one more command before input ready falls.
module calendar_field_adjuster_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // action[2:0], field[5:3], value[12:6], zero[15:13]
    input  logic [cfa_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // hour[4:0], minute[10:5], pm[11], month[15:12], day[20:16], year[27:21],
    // twelve_hour[28], zero[31:29]
    output logic [cfa_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import cfa_pkg::*;

    localparam int STATE_W = $bits(t_cal_state);

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic       r_out_valid;
    t_cal_state r_state;
    t_cal_state n_state;
    logic       w_advance;

    // The state stage may move when its result slot is empty or being emptied.
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd.action <= i_s_axis_tdata[2:0];
            r_cmd.field  <= i_s_axis_tdata[5:3];
            r_cmd.value  <= i_s_axis_tdata[12:6];
        end
    end

    cfa_next_state u_next (
        .i_cmd (r_cmd),
        .i_cur (r_state),
        .o_nxt (n_state)
    );

    // State register, which doubles as the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_state.hour        <= 5'd8;
            r_state.minute      <= 6'd0;
            r_state.pm          <= 1'b0;
            r_state.month       <= 4'd1;
            r_state.day         <= 5'd1;
            r_state.year        <= 7'd0;
            r_state.twelve_hour <= 1'b1;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - STATE_W){1'b0}}, r_state};

endmodule

FILE: design/cfa_checker.sv
// Port-level checker for the calendar adjuster, bound to its top level.
module cfa_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [cfa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [cfa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A result that is not taken stays offered.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result transfer withdrawn while stalled");

    // A stalled result keeps its data.
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // With no result waiting, the block must take a command.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty result slot");

    // Minute, month, year and hour lie in their legal ranges, the hour for the current mode, and the day is not zero.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[10:5] < 6'd60) && (o_m_axis_tdata[15:12] != 4'd0) &&
            (o_m_axis_tdata[15:12] < 4'd13) && (o_m_axis_tdata[20:16] != 5'd0) &&
            (o_m_axis_tdata[27:21] < 7'd100) &&
            (o_m_axis_tdata[28] ? (o_m_axis_tdata[4:0] < 5'd13)
                                : (o_m_axis_tdata[4:0] < 5'd24)))
        else $error("result field out of range");

    // No result is offered straight after reset.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind calendar_field_adjuster_core cfa_port_checker u_cfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: sim/cfa_checker.sv
// Checker for the calendar adjuster: predicts every result from the accepted commands and compares.
module cfa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // action[2:0], field[5:3], value[12:6], zero[15:13]
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // hour[4:0], minute[10:5], pm[11], month[15:12], day[20:16], year[27:21],
    // twelve_hour[28], zero[31:29]
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cfa_pkg::*;

    // Predicted calendar state and the results still owed by the block.
    t_cal_state calendar;
    t_cal_state owed_q[$];
    int         errors = 0;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Days in a month; the year counts from 2000, so year 0 is a leap year.
    function automatic int days_in(input int m, input int y);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
        return 31;
    endfunction

    // Applies one command to the calendar and returns the state that follows.
    function automatic t_cal_state next_calendar(input t_cal_state st, input t_cmd c);
        int         hr, mi, pm, mo, dy, yr, md;
        bit         h12, up;
        t_cal_state nx;
        hr  = st.hour;
        mi  = st.minute;
        pm  = st.pm;
        mo  = st.month;
        dy  = st.day;
        yr  = st.year;
        h12 = st.twelve_hour;
        up  = (c.action == ACT_INC);
        case (c.action)
            ACT_INC, ACT_DEC: begin
                case (c.field)
                    FLD_HOUR: begin
                        if (h12) begin
                            if (up) hr = (hr + 1 > 12) ? hr - 11 : hr + 1;
                            else    hr = (hr < 2) ? hr + 11 : hr - 1;
                        end else begin
                            if (up) hr = (hr + 1 > 23) ? hr - 23 : hr + 1;
                            else    hr = (hr == 0) ? 23 : hr - 1;
                        end
                    end
                    FLD_MINUTE: begin
                        if (up) mi = (mi + 1 > 59) ? mi - 59 : mi + 1;
                        else    mi = (mi == 0) ? 59 : mi - 1;
                    end
                    FLD_PM: pm = pm ^ 1;
                    FLD_MONTH: begin
                        if (up) mo = (mo + 1 > 12) ? mo - 11 : mo + 1;
                        else    mo = (mo < 2) ? mo + 11 : mo - 1;
                        dy = clamp(dy, 1, days_in(mo, yr));
                    end
                    FLD_DAY: begin
                        md = days_in(mo, yr);
                        if (up) dy = (dy + 1 > md) ? dy + 1 - md : dy + 1;
                        else    dy = (dy < 2) ? dy - 1 + md : dy - 1;
                    end
                    FLD_YEAR: begin
                        if (up) yr = (yr + 1 > 99) ? yr - 99 : yr + 1;
                        else    yr = (yr == 0) ? 99 : yr - 1;
                        dy = clamp(dy, 1, days_in(mo, yr));
                    end
                    default: ;
                endcase
            end
            // On the change to 12-hour time, an hour above 12 folds into the afternoon.
            ACT_SEL_12H: begin
                h12 = 1'b1;
                if (hr > 12) begin
                    hr = hr - 12;
                    pm = 1;
                end
            end
            // The PM flag is kept when returning to 24-hour time.
            ACT_SEL_24H: begin
                h12 = 1'b0;
                if (pm != 0 && hr < 12) hr = hr + 12;
            end
            ACT_LOAD: begin
                case (c.field)
                    FLD_HOUR:   hr = h12 ? clamp(c.value, 1, 12) : clamp(c.value, 0, 23);
                    FLD_MINUTE: mi = clamp(c.value, 0, 59);
                    FLD_PM:     pm = clamp(c.value, 0, 1);
                    FLD_MONTH: begin
                        mo = clamp(c.value, 1, 12);
                        dy = clamp(dy, 1, days_in(mo, yr));
                    end
                    FLD_DAY:    dy = clamp(c.value, 1, days_in(mo, yr));
                    FLD_YEAR: begin
                        yr = clamp(c.value, 0, 99);
                        dy = clamp(dy, 1, days_in(mo, yr));
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        nx.hour        = 5'(hr);
        nx.minute      = 6'(mi);
        nx.pm          = pm[0];
        nx.month       = 4'(mo);
        nx.day         = 5'(dy);
        nx.year        = 7'(yr);
        nx.twelve_hour = h12;
        return nx;
    endfunction

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Results are compared before the command of the same edge is predicted, since a
    // result can never belong to a command accepted at that very edge.
    always @(posedge i_clk) begin : watch
        t_cal_state got;
        t_cal_state want;
        t_cmd       cmd;
        if (!i_rst_n) begin
            calendar.hour        = 5'd8;
            calendar.minute      = 6'd0;
            calendar.pm          = 1'b0;
            calendar.month       = 4'd1;
            calendar.day         = 5'd1;
            calendar.year        = 7'd0;
            calendar.twelve_hour = 1'b1;
            owed_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_cal_state'(i_m_tdata[28:0]);
                if (owed_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing expected, expected none, got %h",
                             $time, i_m_tdata);
                end else begin
                    want = owed_q.pop_front();
                    check_field("hour", 7'(want.hour), 7'(got.hour));
                    check_field("minute", 7'(want.minute), 7'(got.minute));
                    check_field("pm", 7'(want.pm), 7'(got.pm));
                    check_field("month", 7'(want.month), 7'(got.month));
                    check_field("day", 7'(want.day), 7'(got.day));
                    check_field("year", 7'(want.year), 7'(got.year));
                    check_field("twelve_hour", 7'(want.twelve_hour), 7'(got.twelve_hour));
                    check_field("padding", 7'd0, 7'(i_m_tdata[31:29]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cmd.action = i_s_tdata[2:0];
                cmd.field  = i_s_tdata[5:3];
                cmd.value  = i_s_tdata[12:6];
                calendar   = next_calendar(calendar, cmd);
                owed_q.push_back(calendar);
            end
        end
        o_fail_count  <= errors;
        o_outstanding <= owed_q.size();
    end

endmodule

FILE: sim/tb_calendar_field_adjuster_core.sv
// Testbench top for the calendar adjuster: clock, reset, command stimulus, result sink and verdict.
module tb_calendar_field_adjuster_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cfa_pkg::*;

    // Codes the block leaves without effect.
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] FLD_UNUSED_FIRST = 3'd6;
    localparam logic [2:0] FLD_UNUSED_LAST  = 3'd7;
    localparam int         RANDOM_ITEMS     = 1750;
    localparam int         CALM_ITEMS       = 200;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // action[2:0], field[5:3], value[12:6], zero[15:13]
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // hour[4:0], minute[10:5], pm[11], month[15:12], day[20:16], year[27:21],
    // twelve_hour[28], zero[31:29]
    logic [31:0] m_tdata;
    int          fail_count;
    int          outstanding;

    // Shared between the sender and the receiver processes.
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    always #5 clk = ~clk;

    calendar_field_adjuster_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    cfa_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offers one command, waits for its transfer and then perhaps leaves a gap.
    task automatic send_cmd(input logic [2:0] act, input logic [2:0] fld,
                            input logic [6:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, fld, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Mostly legal commands with values spread over the whole 7-bit range.
    task automatic pick_cmd(output logic [2:0] act, output logic [2:0] fld,
                            output logic [6:0] val, output bit ignored);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)      act = ACT_INC;
        else if (r < 60) act = ACT_DEC;
        else if (r < 68) act = ACT_SEL_12H;
        else if (r < 76) act = ACT_SEL_24H;
        else if (r < 96) act = ACT_LOAD;
        else             act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        if ($urandom_range(0, 19) == 0)
            fld = 3'($urandom_range(FLD_UNUSED_FIRST, FLD_UNUSED_LAST));
        else
            fld = 3'($urandom_range(FLD_HOUR, FLD_YEAR));
        case ($urandom_range(0, 3))
            0:       val = 7'($urandom_range(0, 127));
            1:       val = 7'($urandom_range(0, 31));
            2:       val = 7'($urandom_range(0, 60));
            default: val = 7'($urandom_range(90, 127));
        endcase
        ignored = (act >= ACT_UNUSED_FIRST) ||
                  ((act == ACT_INC || act == ACT_DEC || act == ACT_LOAD) &&
                   fld >= FLD_UNUSED_FIRST);
    endtask

    // Result sink: random stalls, plus one long hold-off when the sender asks for it.
    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 250;
            end else if (stall == 0 && idle_on && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(1, 14);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Command source and verdict.
    initial begin : source
        logic [2:0] act;
        logic [2:0] fld;
        logic [6:0] val;
        bit         ignored;
        int         n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hour limits and wrap in 12-hour mode, then the mode changes.
        send_cmd(ACT_LOAD, FLD_HOUR, 7'd0);
        send_cmd(ACT_LOAD, FLD_HOUR, 7'd127);
        send_cmd(ACT_INC, FLD_HOUR, 7'd0);
        send_cmd(ACT_DEC, FLD_HOUR, 7'd0);
        send_cmd(ACT_LOAD, FLD_HOUR, 7'd5);
        send_cmd(ACT_LOAD, FLD_PM, 7'd127);
        send_cmd(ACT_SEL_24H, FLD_HOUR, 7'd0);
        send_cmd(ACT_SEL_12H, FLD_MINUTE, 7'd99);
        send_cmd(ACT_SEL_24H, FLD_YEAR, 7'd127);
        // Hour wrap in 24-hour mode, and midnight kept when 12-hour mode returns.
        send_cmd(ACT_LOAD, FLD_HOUR, 7'd127);
        send_cmd(ACT_INC, FLD_HOUR, 7'd0);
        send_cmd(ACT_SEL_12H, FLD_HOUR, 7'd0);
        send_cmd(ACT_DEC, FLD_HOUR, 7'd0);
        send_cmd(ACT_DEC, FLD_PM, 7'd0);
        send_cmd(ACT_INC, FLD_PM, 7'd0);
        // Minute wrap and clamp.
        send_cmd(ACT_DEC, FLD_MINUTE, 7'd0);
        send_cmd(ACT_INC, FLD_MINUTE, 7'd0);
        send_cmd(ACT_LOAD, FLD_MINUTE, 7'd127);
        // Day clamped by month and leap year, year and month wrap.
        send_cmd(ACT_LOAD, FLD_DAY, 7'd127);
        send_cmd(ACT_LOAD, FLD_MONTH, 7'd2);
        send_cmd(ACT_INC, FLD_YEAR, 7'd0);
        send_cmd(ACT_LOAD, FLD_YEAR, 7'd127);
        send_cmd(ACT_INC, FLD_YEAR, 7'd0);
        send_cmd(ACT_LOAD, FLD_MONTH, 7'd0);
        send_cmd(ACT_DEC, FLD_MONTH, 7'd0);
        send_cmd(ACT_INC, FLD_DAY, 7'd0);
        // Codes with no effect.
        send_cmd(ACT_UNUSED_LAST, FLD_UNUSED_LAST, 7'd127);
        send_cmd(ACT_INC, FLD_UNUSED_FIRST, 7'd64);

        // The sender pauses until the block has delivered everything.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering, so input ready falls.
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) begin
            pick_cmd(act, fld, val, ignored);
            send_cmd(act, fld, val);
        end
        idle_on = 1'b1;

        // Random commands; idling stops for the closing stretch.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            pick_cmd(act, fld, val, ignored);
            send_cmd(act, fld, val);
            if (!ignored) n++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
design/cfa_pkg.sv
design/cfa_next_state.sv
design/calendar_field_adjuster_core.sv
design/cfa_checker.sv
sim/cfa_checker.sv
sim/tb_calendar_field_adjuster_core.sv
